/* hw/rtl/btc_pkg.sv */
// Shared types and constants for the block transposition cipher.
// No dependencies; imported by every module of the block.
package btc_pkg;

  localparam int unsigned GroupLen  = 10;
  localparam int unsigned PosW      = 4;
  localparam int unsigned KeyW      = GroupLen * PosW;

  localparam logic [7:0]      PadByte   = 8'h2A;
  localparam logic [7:0]      SpaceByte = 8'h20;
  localparam logic [PosW-1:0] LastPos   = 4'd9;
  localparam logic [KeyW-1:0] KeyReset  = 40'h17_0948_3625;

  typedef logic [GroupLen-1:0][PosW-1:0] key_t;
  typedef logic [GroupLen-1:0][7:0]      group_bytes_t;

  // One finished group as it travels from front to back.
  typedef struct packed {
    group_bytes_t data;
    logic         last;
  } group_t;

  // Key nibble for an output slot, clamped to the last position.
  function automatic logic [PosW-1:0] key_pos(key_t key, logic [PosW-1:0] slot);
    logic [PosW-1:0] p;
    p = key[slot];
    return (p > LastPos) ? LastPos : p;
  endfunction

endpackage

/* hw/rtl/btc_front.sv */
// Front end: accepts message bytes, drops spaces, fills a ten-byte group
// and pushes full or padded groups to the queue. Depends on btc_pkg.
module btc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      in_byte_i,
  input  logic            msg_last_i,
  input  logic            q_full_i,
  output logic            push_o,
  output btc_pkg::group_t push_data_o
);
  import btc_pkg::*;

  logic [PosW-1:0] fill_q, fill_d;
  group_bytes_t    buf_q;
  logic            accept, keep;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign keep       = (in_byte_i != SpaceByte);

  // Group as it stands after this beat, padded past the fill point
  always_comb begin
    for (int p = 0; p < GroupLen; p++) begin
      if (keep && (fill_q == PosW'(p))) begin
        push_data_o.data[p] = in_byte_i;
      end else if (PosW'(p) < fill_q) begin
        push_data_o.data[p] = buf_q[p];
      end else begin
        push_data_o.data[p] = PadByte;
      end
    end
    push_data_o.last = msg_last_i;
  end

  // Push on a completed group, or on message end with anything buffered
  always_comb begin
    push_o = 1'b0;
    fill_d = fill_q;
    if (accept) begin
      if ((keep && fill_q == LastPos) || (msg_last_i && (keep || fill_q != '0))) begin
        push_o = 1'b1;
        fill_d = '0;
      end else if (keep) begin
        fill_d = fill_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Byte store, written at the fill position
  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      buf_q[fill_q] <= in_byte_i;
    end
  end

endmodule

/* hw/rtl/btc_grp_fifo.sv */
// Two-entry queue of finished groups between front and back ends.
// Depends on btc_pkg for the group type.
module btc_grp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  btc_pkg::group_t push_data_i,
  output logic            full_o,
  output logic            empty_o,
  input  logic            pop_i,
  output btc_pkg::group_t head_o
);
  import btc_pkg::*;

  group_t     mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rptr_q];

  // Pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

/* hw/rtl/btc_back.sv */
// Back end: walks the head group slot by slot through the key and drives
// the output register. Depends on btc_pkg.
module btc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  btc_pkg::key_t   key_i,
  input  logic            q_empty_i,
  input  btc_pkg::group_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            group_end_o,
  output logic            msg_end_o
);
  import btc_pkg::*;

  logic [PosW-1:0] slot_q;
  logic            valid_q;
  logic [7:0]      byte_q;
  logic            gend_q, mend_q;
  logic            load, slot_last;

  assign load      = !q_empty_i && (!valid_q || !out_stall_i);
  assign slot_last = (slot_q == LastPos);
  assign pop_o     = load && slot_last;

  // Slot counter and output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        slot_q  <= slot_last ? '0 : slot_q + PosW'(1);
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.data[key_pos(key_i, slot_q)];
      gend_q <= slot_last;
      mend_q <= slot_last && head_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign group_end_o = gend_q;
  assign msg_end_o   = mend_q;

endmodule

/* hw/rtl/block_transposition_cipher_top.sv */
// Block transposition cipher top level: key register, front end, group queue
// and back end. Output: one beat per cycle while out_stall_i is low and a group
// is queued, ten beats per group.
// Input: one byte per cycle while the two-entry group queue has room; a full
// queue stalls it until the back end pops a group on its tenth beat.
// Reset (rst_ni, async low) empties queue and fill count, loads the default key.
module block_transposition_cipher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [39:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        msg_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        group_end_o,
  output logic        msg_end_o
);
  import btc_pkg::*;

  logic [KeyW-1:0] key_q;
  logic            push, pop, q_full, q_empty;
  group_t          push_data, head;

  assign cfg_ready_o = 1'b1;

  // Permutation key register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= KeyReset;
    end else if (cfg_valid_i) begin
      key_q <= cfg_data_i;
    end
  end

  btc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .msg_last_i  (msg_last_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  btc_grp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .pop_i       (pop),
    .head_o      (head)
  );

  btc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key_t'(key_q)),
    .q_empty_i   (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .group_end_o (group_end_o),
    .msg_end_o   (msg_end_o)
  );

endmodule
